// File: hdl/unf_pkg.sv
// ----------------------------------------------------------------------------
// unf_pkg: shared types and constants for the unit normal block
// Component widths, lane record passed down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package unf_pkg;

  localparam int COMP_WIDTH    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
  localparam int PROD_W        = 2 * COMP_WIDTH;
  localparam int CROSS_W       = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int N_W           = OUT_FRAC_BITS + 1;
  localparam int REM_W         = SQ_W + 2 * OUT_FRAC_BITS + 4;
  localparam int BIT_IDX_W     = $clog2(N_W);

  // one lane of the quotient search: remainder, running n*s, partial n
  typedef struct packed {
    logic [SQ_W-1:0]  s;
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] m;
    logic [N_W-1:0]   n;
    logic             neg;
  } lane_t;

endpackage
`default_nettype wire

// File: hdl/unf_cell.sv
// ----------------------------------------------------------------------------
// unf_cell: one bit of the normalized quotient
// Tries n | 2^b against the remainder c^2*2^2F - n^2*s and keeps it if it fits.
// ----------------------------------------------------------------------------
`default_nettype none
module unf_cell (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [unf_pkg::BIT_IDX_W-1:0]  bit_idx,
  input  wire unf_pkg::lane_t                 lane_i,
  output unf_pkg::lane_t                      lane_o
);
  import unf_pkg::*;

  lane_t            lane_r, lane_nxt;
  logic [REM_W-1:0] sb;
  logic [REM_W-1:0] trial;

  always_comb begin
    // (n+2^b)^2 s - n^2 s = 2^b (2 n s + 2^b s)
    sb       = REM_W'(lane_i.s) << bit_idx;
    trial    = ({lane_i.m[REM_W-2:0], 1'b0} + sb) << bit_idx;
    lane_nxt = lane_i;
    if (trial <= lane_i.d) begin
      lane_nxt.d = lane_i.d - trial;
      lane_nxt.m = lane_i.m + sb;
      lane_nxt.n = lane_i.n | (N_W'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

// File: hdl/unit_normal_from_cross.sv
// ----------------------------------------------------------------------------
// unit_normal_from_cross: unit normal of two 3-D vectors
// Cross product, length and per-component quotient as a pipelined cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: a_x..b_z, signed Q8.8, taken when in_valid is high and
//   in_stall is low. Output beat: n_x..n_z signed Q1.14 (16384 is one),
//   truncated toward zero, plus degenerate when the cross product is zero
//   (normal is then all zero).
//   Registers in order: six products, differences, squares, length sum,
//   one cell per quotient bit (15 cells in each of three lanes), output reg.
//   Throughput is one beat per cycle; the whole pipe advances together and
//   holds only while a finished output beat is stalled, so in_stall is
//   out_valid and out_stall.
//   Synchronous reset clears all valid flags; no state survives an item.
// ----------------------------------------------------------------------------
`default_nettype none
module unit_normal_from_cross (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_a_x,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_a_y,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_a_z,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_b_x,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_b_y,
  input  wire logic signed [unf_pkg::COMP_WIDTH-1:0] in_b_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [unf_pkg::OUT_WIDTH-1:0]     out_n_x,
  output logic signed [unf_pkg::OUT_WIDTH-1:0]     out_n_y,
  output logic signed [unf_pkg::OUT_WIDTH-1:0]     out_n_z,
  output logic                                     out_degenerate
);
  import unf_pkg::*;

  logic en;

  // stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] p_r [6];
  // stage 2: cross components
  logic                     v2_r;
  logic [MAG_W-1:0]         mag_r [3];
  logic                     neg2_r [3];
  // stage 3: squares
  logic                     v3_r;
  logic [SQ_W-1:0]          sq_r [3];
  logic                     neg3_r [3];
  // stage 4: lane seeds
  logic                     v4_r;
  logic                     dg4_r;
  lane_t                    seed_r [3];
  logic [SQ_W-1:0]          s_sum;
  // cell chain
  lane_t                    chain [3][N_W+1];
  logic                     vc_r [N_W];
  logic                     dgc_r [N_W];
  // output
  logic signed [OUT_WIDTH-1:0] n_nxt [3];
  logic signed [OUT_WIDTH-1:0] n_r   [3];
  logic                        out_valid_r;
  logic                        dg_out_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < N_W; k++) vc_r[k] <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vc_r[0]     <= v4_r;
      for (int k = 1; k < N_W; k++) vc_r[k] <= vc_r[k-1];
      out_valid_r <= vc_r[N_W-1];
    end
  end

  always_comb begin
    s_sum = sq_r[0] + sq_r[1] + sq_r[2];
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_a_y * in_b_z;
      p_r[1] <= in_a_z * in_b_y;
      p_r[2] <= in_a_z * in_b_x;
      p_r[3] <= in_a_x * in_b_z;
      p_r[4] <= in_a_x * in_b_y;
      p_r[5] <= in_a_y * in_b_x;
      for (int i = 0; i < 3; i++) begin
        logic signed [CROSS_W-1:0] c;
        c         = CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
        neg2_r[i] <= c[CROSS_W-1];
        mag_r[i]  <= c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
        sq_r[i]   <= mag_r[i] * mag_r[i];
        neg3_r[i] <= neg2_r[i];
        seed_r[i].s   <= s_sum;
        seed_r[i].d   <= REM_W'(sq_r[i]) << (2 * OUT_FRAC_BITS);
        seed_r[i].m   <= '0;
        seed_r[i].n   <= '0;
        seed_r[i].neg <= neg3_r[i];
      end
      dg4_r    <= (s_sum == '0);
      dgc_r[0] <= dg4_r;
      for (int k = 1; k < N_W; k++) dgc_r[k] <= dgc_r[k-1];
      dg_out_r <= dgc_r[N_W-1];
      for (int i = 0; i < 3; i++) n_r[i] <= n_nxt[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign chain[i][0] = seed_r[i];
    for (genvar k = 0; k < N_W; k++) begin : g_cell
      unf_cell u_cell (
        .clk     (clk),
        .en      (en),
        .bit_idx (BIT_IDX_W'(N_W - 1 - k)),
        .lane_i  (chain[i][k]),
        .lane_o  (chain[i][k+1])
      );
    end
  end

  // apply sign, drop to zero on a zero cross product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dgc_r[N_W-1]) begin
        n_nxt[i] = '0;
      end else if (chain[i][N_W].neg) begin
        n_nxt[i] = -OUT_WIDTH'(chain[i][N_W].n);
      end else begin
        n_nxt[i] = OUT_WIDTH'(chain[i][N_W].n);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_n_x        = n_r[0];
  assign out_n_y        = n_r[1];
  assign out_n_z        = n_r[2];
  assign out_degenerate = dg_out_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_n_x == 0 && out_n_y == 0 && out_n_z == 0)
    else $error("degenerate beat with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_n_x <= 16384 && out_n_x >= -16384 &&
                  out_n_y <= 16384 && out_n_y >= -16384 &&
                  out_n_z <= 16384 && out_n_z >= -16384)
    else $error("normal component beyond one");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(n_r[0]) && $stable(dg_out_r))
    else $error("pipe advanced under stall");

endmodule
`default_nettype wire
